FILE: hw/rtl/rhp_pkg.sv
// Shared types and codes for the radiotap header parser.
`timescale 1ns / 1ps

package rhp_pkg;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_FIELDS = 4'b0010,
        PH_DONE   = 4'b0100,
        PH_IGNORE = 4'b1000
    } phase_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_VER   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_SHORT_LEN = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic        field_overflow;
        logic [15:0] underflow_bytes;
        logic [15:0] header_length;
        logic [31:0] present_bitmap;
        logic [7:0]  flags_byte;
        logic        flags_seen;
        logic [15:0] rx_flags_word;
        logic        rx_flags_seen;
        logic [15:0] rx_unknown_bits;
    } rhp_result_t;

endpackage

FILE: hw/rtl/rhp_field_parser.sv
// Per-packet parse state and the byte-by-byte field walker.
`timescale 1ns / 1ps

module rhp_field_parser import rhp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        res_valid,
    output rhp_result_t res_data
);

    localparam logic [31:0] SIZED_MASK = 32'h4038_7FFF;
    localparam logic [7:0]  FLAGS_ID   = 8'd1;
    localparam logic [7:0]  RX_ID      = 8'd14;

    function automatic logic [3:0] field_size(input logic [4:0] idx);
        logic [3:0] sz;
        case (idx)
            5'd0:    sz = 4'd8;
            5'd1:    sz = 4'd1;
            5'd2:    sz = 4'd1;
            5'd3:    sz = 4'd4;
            5'd4:    sz = 4'd2;
            5'd5:    sz = 4'd1;
            5'd6:    sz = 4'd1;
            5'd7:    sz = 4'd2;
            5'd8:    sz = 4'd2;
            5'd9:    sz = 4'd2;
            5'd10:   sz = 4'd1;
            5'd11:   sz = 4'd1;
            5'd12:   sz = 4'd1;
            5'd13:   sz = 4'd1;
            5'd14:   sz = 4'd2;
            5'd19:   sz = 4'd3;
            5'd20:   sz = 4'd8;
            5'd21:   sz = 4'd12;
            5'd30:   sz = 4'd6;
            default: sz = 4'd0;
        endcase
        return sz;
    endfunction

    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] bitmap_reg, bitmap_next;
    logic [4:0]  cur_idx_reg, cur_idx_next;
    logic [3:0]  left_reg, left_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [7:0]  flags_reg, flags_next;
    logic [15:0] rx_reg, rx_next;
    phase_t      phase_reg, phase_next;
    logic        vbad_reg, vbad_next;
    logic        ovf_reg, ovf_next;
    logic        fseen_reg, fseen_next;
    logic        rxseen_reg, rxseen_next;
    logic [15:0] under_reg, under_next;

    logic [15:0] rem;
    logic [31:0] avail;
    logic [31:0] fit;
    logic [31:0] cand;
    logic [31:0] pick;
    logic [31:0] upto;
    logic [4:0]  pick_idx;
    logic [31:0] consumed_new;
    logic [3:0]  left_eff;
    logic        take;
    logic [31:0] bitmap_full;

    always_comb begin
        rem = len_reg - pos_reg;
        avail = bitmap_reg & ~consumed_reg;
        for (int i = 0; i < 32; i++) begin
            fit[i] = (field_size(5'(i)) != 4'd0) && (rem >= {12'd0, field_size(5'(i))});
        end
        cand = avail & fit;
        pick = cand & (~cand + 32'd1);
        upto = pick | (pick - 32'd1);
        pick_idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (cand[i]) begin
                pick_idx = 5'(i);
            end
        end
    end

    always_comb begin
        pos_next      = (pos_reg == 16'hFFFF) ? pos_reg : pos_reg + 16'd1;
        len_next      = len_reg;
        bitmap_next   = bitmap_reg;
        cur_idx_next  = cur_idx_reg;
        left_next     = left_reg;
        consumed_next = consumed_reg;
        flags_next    = flags_reg;
        rx_next       = rx_reg;
        phase_next    = phase_reg;
        vbad_next     = vbad_reg;
        ovf_next      = ovf_reg;
        fseen_next    = fseen_reg;
        rxseen_next   = rxseen_reg;
        under_next    = under_reg;
        consumed_new  = consumed_reg;
        left_eff      = left_reg;
        take          = 1'b0;
        bitmap_full   = {byte_value, bitmap_reg[23:0]};

        if (pos_reg < 16'd8) begin
            case (pos_reg[2:0])
                3'd0:    vbad_next = (byte_value != 8'd0);
                3'd2:    len_next = {8'd0, byte_value};
                3'd3:    len_next = {byte_value, len_reg[7:0]};
                3'd4:    bitmap_next[7:0] = byte_value;
                3'd5:    bitmap_next[15:8] = byte_value;
                3'd6:    bitmap_next[23:16] = byte_value;
                3'd7:    bitmap_next[31:24] = byte_value;
                default: ;
            endcase
            if (pos_reg[2:0] == 3'd7) begin
                if (vbad_reg || len_reg < 16'd8) begin
                    phase_next = PH_IGNORE;
                end else if (len_reg == 16'd8) begin
                    ovf_next   = |(bitmap_full & SIZED_MASK);
                    under_next = '0;
                    phase_next = PH_DONE;
                end else begin
                    phase_next = PH_FIELDS;
                end
            end
        end else if (phase_reg == PH_FIELDS && pos_reg < len_reg) begin
            if (left_reg == 4'd0) begin
                if (cand == '0) begin
                    consumed_next = '1;
                    ovf_next      = ovf_reg | (|(avail & SIZED_MASK));
                    under_next    = rem;
                    phase_next    = PH_DONE;
                end else begin
                    take          = 1'b1;
                    consumed_new  = consumed_reg | upto;
                    consumed_next = consumed_new;
                    ovf_next      = ovf_reg | (|(avail & SIZED_MASK & upto & ~pick));
                    cur_idx_next  = pick_idx;
                    left_eff      = field_size(pick_idx);
                    if (pick_idx == FLAGS_ID[4:0]) begin
                        flags_next = byte_value;
                        fseen_next = 1'b1;
                    end
                    if (pick_idx == RX_ID[4:0]) begin
                        rx_next[7:0] = byte_value;
                    end
                end
            end else begin
                take = 1'b1;
                if (cur_idx_reg == RX_ID[4:0] && left_reg == 4'd1) begin
                    rx_next[15:8] = byte_value;
                    rxseen_next   = 1'b1;
                end
            end
            if (take) begin
                left_next = left_eff - 4'd1;
                if (left_next == 4'd0 && rem == 16'd1) begin
                    ovf_next   = ovf_next | (|(bitmap_reg & ~consumed_new & SIZED_MASK));
                    under_next = '0;
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // Result built from the post-update state of the final byte.
    always_comb begin
        res_valid = fire && last_byte;
        res_data  = '0;
        if (vbad_next) begin
            res_data.status = ST_BAD_VER;
        end else if (pos_next < 16'd8) begin
            res_data.status = ST_TRUNCATED;
        end else begin
            res_data.header_length  = len_next;
            res_data.present_bitmap = bitmap_next;
            if (len_next < 16'd8) begin
                res_data.status         = ST_SHORT_LEN;
                res_data.field_overflow = (bitmap_next != '0);
            end else begin
                res_data.flags_byte      = flags_next;
                res_data.flags_seen      = fseen_next;
                res_data.rx_flags_word   = rx_next;
                res_data.rx_flags_seen   = rxseen_next;
                res_data.rx_unknown_bits = {rx_next[15:2], 2'b00};
                if (pos_next < len_next) begin
                    res_data.status = ST_TRUNCATED;
                end else begin
                    res_data.status          = ST_OK;
                    res_data.field_overflow  = ovf_next;
                    res_data.underflow_bytes = under_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && last_byte)) begin
            pos_reg      <= '0;
            len_reg      <= '0;
            bitmap_reg   <= '0;
            cur_idx_reg  <= '0;
            left_reg     <= '0;
            consumed_reg <= '0;
            flags_reg    <= '0;
            rx_reg       <= '0;
            phase_reg    <= PH_HEADER;
            vbad_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            fseen_reg    <= 1'b0;
            rxseen_reg   <= 1'b0;
            under_reg    <= '0;
        end else if (fire) begin
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            bitmap_reg   <= bitmap_next;
            cur_idx_reg  <= cur_idx_next;
            left_reg     <= left_next;
            consumed_reg <= consumed_next;
            flags_reg    <= flags_next;
            rx_reg       <= rx_next;
            phase_reg    <= phase_next;
            vbad_reg     <= vbad_next;
            ovf_reg      <= ovf_next;
            fseen_reg    <= fseen_next;
            rxseen_reg   <= rxseen_next;
            under_reg    <= under_next;
        end
    end

endmodule

FILE: hw/rtl/rhp_out_buffer.sv
// Result output register with one skid entry.
`timescale 1ns / 1ps

module rhp_out_buffer import rhp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  rhp_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rhp_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    rhp_result_t out_data_reg, out_data_next;
    rhp_result_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                if (in_valid) begin
                    out_data_next = in_data;
                end
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

FILE: hw/rtl/radiotap_header_parser.sv
// Radiotap header parser top level: input register, field walker, result buffer.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one captured byte per transaction,
//   s_byte_value, with s_last_byte set on the final byte of each packet.
//   Output channel (m_valid/m_ready) carries one result transaction per packet:
//   status, overflow flag, unused header bytes, length, present bitmap and the
//   flags and RX-flags fields.
//   Throughput: one byte per cycle, sustained across packet boundaries while
//   the result buffer has room. m_valid rises once the last byte has passed the
//   input register and its result has been registered in the result register.
//   Reset (aresetn low, synchronous) empties the input register and the result
//   buffer and puts the parser at the start of a packet.
//   When the receiver stalls, one finished result waits in the output register
//   and a second one in a skid entry; bytes keep flowing until that skid entry
//   fills, then the parser holds and s_ready drops once the input register is
//   occupied, until the receiver takes a result.
`timescale 1ns / 1ps

module radiotap_header_parser import rhp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_field_overflow,
    output logic [15:0] m_underflow_bytes,
    output logic [15:0] m_header_length,
    output logic [31:0] m_present_bitmap,
    output logic [7:0]  m_flags_byte,
    output logic        m_flags_seen,
    output logic [15:0] m_rx_flags_word,
    output logic        m_rx_flags_seen,
    output logic [15:0] m_rx_unknown_bits
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        buf_ready;
    logic        proc_fire;
    logic        s_fire;
    logic        res_valid;
    rhp_result_t res_data;
    rhp_result_t out_data;

    assign proc_fire = in_valid_reg && buf_ready;
    assign s_ready   = !in_valid_reg || buf_ready;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_fire) begin
            in_byte_reg <= s_byte_value;
            in_last_reg <= s_last_byte;
        end
    end

    rhp_field_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (proc_fire),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    rhp_out_buffer u_out_buffer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (buf_ready),
        .in_data   (res_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_status          = out_data.status;
    assign m_field_overflow  = out_data.field_overflow;
    assign m_underflow_bytes = out_data.underflow_bytes;
    assign m_header_length   = out_data.header_length;
    assign m_present_bitmap  = out_data.present_bitmap;
    assign m_flags_byte      = out_data.flags_byte;
    assign m_flags_seen      = out_data.flags_seen;
    assign m_rx_flags_word   = out_data.rx_flags_word;
    assign m_rx_flags_seen   = out_data.rx_flags_seen;
    assign m_rx_unknown_bits = out_data.rx_unknown_bits;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for radiotap_header_parser: directed and random packets, predicted results.
`timescale 1ns / 1ps

module tb_top;
    import rhp_pkg::*;

    localparam int          FLAGS_FIELD     = 1;
    localparam int          RX_FLAGS_FIELD  = 14;
    localparam int          NO_FIELD        = 32;
    localparam logic [15:0] RX_KNOWN_BITS   = 16'h0003;
    localparam int          RANDOM_BYTES    = 1250;
    localparam int          HANG_LIMIT      = 2000;

    typedef struct packed {
        logic [7:0] data;
        logic       last_flag;
    } packet_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_field_overflow;
    logic [15:0] m_underflow_bytes;
    logic [15:0] m_header_length;
    logic [31:0] m_present_bitmap;
    logic [7:0]  m_flags_byte;
    logic        m_flags_seen;
    logic [15:0] m_rx_flags_word;
    logic        m_rx_flags_seen;
    logic [15:0] m_rx_unknown_bits;

    packet_byte_t pending_bytes[$];
    logic [7:0]   pkt_bytes[$];
    rhp_result_t  expected_results[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int stall_draw;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    // parser shadow state
    int unsigned  rx_pos;
    logic [15:0]  len_w;
    logic [31:0]  bmap;
    logic [4:0]   fidx;
    logic [3:0]   fleft;
    logic [31:0]  done_mask;
    logic [23:0]  cap;
    phase_t       phase;
    bit           vbad;
    bit           ovf;
    bit           fseen;
    bit           rxseen;
    logic [15:0]  unused_cnt;

    radiotap_header_parser DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_byte_value      (s_byte_value),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_field_overflow  (m_field_overflow),
        .m_underflow_bytes (m_underflow_bytes),
        .m_header_length   (m_header_length),
        .m_present_bitmap  (m_present_bitmap),
        .m_flags_byte      (m_flags_byte),
        .m_flags_seen      (m_flags_seen),
        .m_rx_flags_word   (m_rx_flags_word),
        .m_rx_flags_seen   (m_rx_flags_seen),
        .m_rx_unknown_bits (m_rx_unknown_bits)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int field_width(input int idx);
        case (idx)
            0, 20: return 8;
            1, 2, 5, 6, 10, 11, 12, 13: return 1;
            3: return 4;
            4, 7, 8, 9, 14: return 2;
            19: return 3;
            21: return 12;
            30: return 6;
            default: return 0;
        endcase
    endfunction

    function automatic void clear_packet_state();
        rx_pos = 0;
        len_w = '0;
        bmap = '0;
        fidx = '0;
        fleft = '0;
        done_mask = '0;
        cap = '0;
        phase = PH_HEADER;
        vbad = 1'b0;
        ovf = 1'b0;
        fseen = 1'b0;
        rxseen = 1'b0;
        unused_cnt = '0;
    endfunction

    // remaining present fields are settled against the header end
    function automatic void settle_layout(input int unsigned at);
        for (int i = 0; i < 32; i++) begin
            if (bmap[i] && !done_mask[i]) begin
                done_mask[i] = 1'b1;
                if (at + field_width(i) > len_w) ovf = 1'b1;
            end
        end
        unused_cnt = 16'(len_w - at);
        phase = PH_DONE;
    endfunction

    function automatic int next_field(input int unsigned at);
        for (int i = 0; i < 32; i++) begin
            if (bmap[i] && !done_mask[i]) begin
                done_mask[i] = 1'b1;
                if (field_width(i) != 0) begin
                    if (at + field_width(i) <= len_w) return i;
                    ovf = 1'b1;
                end
            end
        end
        return NO_FIELD;
    endfunction

    function automatic void parse_field_byte(input int unsigned at, input logic [7:0] b);
        int idx;
        int off;
        if (fleft == 0) begin
            idx = next_field(at);
            if (idx == NO_FIELD) begin
                settle_layout(at);
                return;
            end
            fidx = idx[4:0];
            fleft = 4'(field_width(idx));
        end
        off = field_width(fidx) - fleft;
        if (fidx == FLAGS_FIELD && off == 0) begin
            cap[7:0] = b;
            fseen = 1'b1;
        end else if (fidx == RX_FLAGS_FIELD && off == 0) begin
            cap[15:8] = b;
        end else if (fidx == RX_FLAGS_FIELD && off == 1) begin
            cap[23:16] = b;
            rxseen = 1'b1;
        end
        fleft = fleft - 1'b1;
        if (fleft == 0 && at + 1 == len_w) settle_layout(at + 1);
    endfunction

    function automatic void accept_byte(input logic [7:0] b, input logic last_flag);
        int unsigned p;
        rhp_result_t r;
        p = rx_pos;
        if (p < 8) begin
            case (p)
                0: vbad = (b != 8'h00);
                2: len_w[7:0] = b;
                3: len_w[15:8] = b;
                4, 5, 6, 7: bmap[8 * (p - 4) +: 8] = b;
                default: ;
            endcase
            if (p == 7) begin
                if (vbad || len_w < 8) begin
                    phase = PH_IGNORE;
                end else begin
                    phase = PH_FIELDS;
                    if (len_w == 8) settle_layout(8);
                end
            end
        end else if (phase == PH_FIELDS && p < len_w) begin
            parse_field_byte(p, b);
        end
        if (rx_pos < 65535) rx_pos = rx_pos + 1;
        if (!last_flag) return;

        r = '0;
        if (vbad) begin
            r.status = ST_BAD_VER;
        end else if (rx_pos < 8) begin
            r.status = ST_TRUNCATED;
        end else begin
            r.header_length = len_w;
            r.present_bitmap = bmap;
            if (len_w < 8) begin
                r.status = ST_SHORT_LEN;
                r.field_overflow = (bmap != 0);
            end else begin
                r.flags_byte = cap[7:0];
                r.flags_seen = fseen;
                r.rx_flags_word = cap[23:8];
                r.rx_flags_seen = rxseen;
                r.rx_unknown_bits = cap[23:8] & ~RX_KNOWN_BITS;
                if (rx_pos < len_w) begin
                    r.status = ST_TRUNCATED;
                end else begin
                    r.status = ST_OK;
                    r.field_overflow = ovf;
                    r.underflow_bytes = unused_cnt;
                end
            end
        end
        expected_results.push_back(r);
        clear_packet_state();
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        rhp_result_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, m_status);
            mismatches++;
        end else begin
            want = expected_results.pop_front();
            check_field("status", 32'(want.status), 32'(m_status));
            check_field("field_overflow", 32'(want.field_overflow), 32'(m_field_overflow));
            check_field("underflow_bytes", 32'(want.underflow_bytes),
                        32'(m_underflow_bytes));
            check_field("header_length", 32'(want.header_length), 32'(m_header_length));
            check_field("present_bitmap", want.present_bitmap, m_present_bitmap);
            check_field("flags_byte", 32'(want.flags_byte), 32'(m_flags_byte));
            check_field("flags_seen", 32'(want.flags_seen), 32'(m_flags_seen));
            check_field("rx_flags_word", 32'(want.rx_flags_word), 32'(m_rx_flags_word));
            check_field("rx_flags_seen", 32'(want.rx_flags_seen), 32'(m_rx_flags_seen));
            check_field("rx_unknown_bits", 32'(want.rx_unknown_bits),
                        32'(m_rx_unknown_bits));
        end
    endtask

    task automatic put_header(input logic [7:0] ver, input logic [15:0] len,
                              input logic [31:0] bm);
        pkt_bytes.delete();
        pkt_bytes.push_back(ver);
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(len[7:0]);
        pkt_bytes.push_back(len[15:8]);
        for (int i = 0; i < 4; i++) pkt_bytes.push_back(bm[8 * i +: 8]);
    endtask

    // bytes past the built part are random
    task automatic flush_packet(input int count);
        packet_byte_t pb;
        for (int i = 0; i < count; i++) begin
            pb.data = (i < pkt_bytes.size()) ? pkt_bytes[i] : 8'($urandom);
            pb.last_flag = (i == count - 1);
            pending_bytes.push_back(pb);
        end
    endtask

    task automatic add_wellformed();
        logic [31:0] bm;
        int total;
        int len;
        int count;
        case ($urandom_range(0, 3))
            0: bm = $urandom & $urandom & $urandom;
            1: bm = $urandom & $urandom;
            2: bm = $urandom;
            default: bm = $urandom & 32'h0000_7FFF;
        endcase
        if ($urandom_range(0, 1) == 1) bm = bm | 32'h0000_4002;
        total = 8;
        for (int i = 0; i < 32; i++) if (bm[i]) total += field_width(i);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = total;
            5, 6: len = total - $urandom_range(0, total - 8);
            7, 8: len = total + $urandom_range(1, 6);
            default: len = $urandom_range(8, total + 2);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: count = len;
            6, 7: count = len + $urandom_range(1, 3);
            8: count = $urandom_range(8, len);
            default: count = $urandom_range(1, 7);
        endcase
        put_header(8'h00, len[15:0], bm);
        flush_packet(count);
    endtask

    task automatic add_noise();
        case ($urandom_range(0, 3))
            0: begin
                put_header(8'($urandom_range(1, 255)), 16'($urandom), $urandom);
                flush_packet($urandom_range(1, 12));
            end
            1: begin
                put_header(8'h00, 16'($urandom_range(0, 7)),
                           ($urandom_range(0, 1) == 1) ? $urandom : 32'h0);
                flush_packet($urandom_range(8, 12));
            end
            2: begin
                put_header(($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom),
                           16'($urandom), $urandom);
                flush_packet($urandom_range(1, 12));
            end
            default: begin
                put_header(8'h00, 16'($urandom), $urandom);
                flush_packet($urandom_range(1, 9));
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait <= 0;
            clear_packet_state();
        end else if (!s_valid || s_ready) begin
            if (s_valid) accept_byte(s_byte_value, s_last_byte);
            if (send_wait != 0) begin
                s_valid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pending_bytes.size() != 0) begin
                s_valid <= 1'b1;
                {s_byte_value, s_last_byte} <= pending_bytes.pop_front();
                if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
                send_wait <= send_burst ? 0 : $urandom_range(0, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait <= 0;
        end else if (m_valid && m_ready) begin
            check_result();
            if ($urandom_range(0, 39) == 0) recv_burst <= !recv_burst;
            stall_draw = recv_burst ? 0 : $urandom_range(0, 4);
            m_ready <= (stall_draw == 0);
            recv_wait <= (stall_draw == 0) ? 0 : stall_draw - 1;
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= HANG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        // bad version on a one-byte packet
        put_header(8'hFF, 16'h0000, 32'h0);
        flush_packet(1);
        // header length exactly 8, every field present and none fits
        put_header(8'h00, 16'd8, 32'hFFFF_FFFF);
        flush_packet(8);
        // header length below 8
        put_header(8'h00, 16'd7, 32'h0);
        flush_packet(8);
        // flags and RX flags, all ones RX word
        put_header(8'h00, 16'd11, 32'h0000_4002);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(8'hFF);
        flush_packet(11);

        while (pending_bytes.size() < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) < 7) add_wellformed();
            else add_noise();
        end

        // maximum header length, packet ends early
        put_header(8'h00, 16'hFFFF, 32'h8000_4002);
        flush_packet(12);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
